// ===== hdl/rvd_pkg.sv =====
// Package for the RV32I instruction decoder: opcode, operation and format codes,
// the decode result type and the funct3 lookup functions.
// Depends on nothing; used by rvd_decode and rv32i_instruction_decoder.
package rvd_pkg;

    localparam int INSTR_W = 32;
    localparam int OP_W    = 6;
    localparam int FMT_W   = 3;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 32;

    // Major opcodes, bits 6:0
    localparam logic [6:0] OPC_LUI    = 7'd55;
    localparam logic [6:0] OPC_AUIPC  = 7'd23;
    localparam logic [6:0] OPC_JAL    = 7'd111;
    localparam logic [6:0] OPC_JALR   = 7'd103;
    localparam logic [6:0] OPC_OPIMM  = 7'd19;
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_BRANCH = 7'd99;
    localparam logic [6:0] OPC_OP     = 7'd51;
    localparam logic [6:0] OPC_STORE  = 7'd35;

    localparam logic [6:0] F7_ZERO = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SRL  = 3'd5;

    // Format classes
    localparam logic [FMT_W-1:0] FMT_U = 3'd0;
    localparam logic [FMT_W-1:0] FMT_J = 3'd1;
    localparam logic [FMT_W-1:0] FMT_I = 3'd2;
    localparam logic [FMT_W-1:0] FMT_L = 3'd3;
    localparam logic [FMT_W-1:0] FMT_B = 3'd4;
    localparam logic [FMT_W-1:0] FMT_R = 3'd5;
    localparam logic [FMT_W-1:0] FMT_S = 3'd6;

    // Operations
    localparam logic [OP_W-1:0] OP_LUI   = 6'd0;
    localparam logic [OP_W-1:0] OP_AUIPC = 6'd1;
    localparam logic [OP_W-1:0] OP_JAL   = 6'd2;
    localparam logic [OP_W-1:0] OP_JALR  = 6'd3;
    localparam logic [OP_W-1:0] OP_BEQ   = 6'd4;
    localparam logic [OP_W-1:0] OP_BNE   = 6'd5;
    localparam logic [OP_W-1:0] OP_BLT   = 6'd6;
    localparam logic [OP_W-1:0] OP_BGE   = 6'd7;
    localparam logic [OP_W-1:0] OP_BLTU  = 6'd8;
    localparam logic [OP_W-1:0] OP_BGEU  = 6'd9;
    localparam logic [OP_W-1:0] OP_LB    = 6'd10;
    localparam logic [OP_W-1:0] OP_LH    = 6'd11;
    localparam logic [OP_W-1:0] OP_LW    = 6'd12;
    localparam logic [OP_W-1:0] OP_LBU   = 6'd13;
    localparam logic [OP_W-1:0] OP_LHU   = 6'd14;
    localparam logic [OP_W-1:0] OP_SB    = 6'd15;
    localparam logic [OP_W-1:0] OP_SH    = 6'd16;
    localparam logic [OP_W-1:0] OP_SW    = 6'd17;
    localparam logic [OP_W-1:0] OP_ADDI  = 6'd18;
    localparam logic [OP_W-1:0] OP_SLTI  = 6'd19;
    localparam logic [OP_W-1:0] OP_SLTIU = 6'd20;
    localparam logic [OP_W-1:0] OP_XORI  = 6'd21;
    localparam logic [OP_W-1:0] OP_ORI   = 6'd22;
    localparam logic [OP_W-1:0] OP_ANDI  = 6'd23;
    localparam logic [OP_W-1:0] OP_SLLI  = 6'd24;
    localparam logic [OP_W-1:0] OP_SRLI  = 6'd25;
    localparam logic [OP_W-1:0] OP_SRAI  = 6'd26;
    localparam logic [OP_W-1:0] OP_ADD   = 6'd27;
    localparam logic [OP_W-1:0] OP_SUB   = 6'd28;
    localparam logic [OP_W-1:0] OP_SLL   = 6'd29;
    localparam logic [OP_W-1:0] OP_SLT   = 6'd30;
    localparam logic [OP_W-1:0] OP_SLTU  = 6'd31;
    localparam logic [OP_W-1:0] OP_XOR   = 6'd32;
    localparam logic [OP_W-1:0] OP_SRL   = 6'd33;
    localparam logic [OP_W-1:0] OP_SRA   = 6'd34;
    localparam logic [OP_W-1:0] OP_OR    = 6'd35;
    localparam logic [OP_W-1:0] OP_AND   = 6'd36;
    localparam logic [OP_W-1:0] OP_LAST  = OP_AND;

    typedef struct packed {
        logic                    ok;
        logic [OP_W-1:0]         op;
    } op_entry_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [FMT_W-1:0]        format;
        logic                    illegal;
        logic [REG_W-1:0]        src1_reg;
        logic                    src1_used;
        logic [REG_W-1:0]        src2_reg;
        logic                    src2_used;
        logic [REG_W-1:0]        dest_reg;
        logic                    dest_used;
        logic signed [IMM_W-1:0] immediate;
    } dec_result_t;

    function automatic op_entry_t branch_op(input logic [2:0] f3);
        op_entry_t e;
        e = '{ok: 1'b1, op: OP_BEQ};
        unique case (f3)
            3'd0:    e.op = OP_BEQ;
            3'd1:    e.op = OP_BNE;
            3'd4:    e.op = OP_BLT;
            3'd5:    e.op = OP_BGE;
            3'd6:    e.op = OP_BLTU;
            3'd7:    e.op = OP_BGEU;
            default: e = '{ok: 1'b0, op: '0};
        endcase
        return e;
    endfunction

    function automatic op_entry_t load_op(input logic [2:0] f3);
        op_entry_t e;
        e = '{ok: 1'b1, op: OP_LB};
        unique case (f3)
            3'd0:    e.op = OP_LB;
            3'd1:    e.op = OP_LH;
            3'd2:    e.op = OP_LW;
            3'd4:    e.op = OP_LBU;
            3'd5:    e.op = OP_LHU;
            default: e = '{ok: 1'b0, op: '0};
        endcase
        return e;
    endfunction

    function automatic op_entry_t store_op(input logic [2:0] f3);
        op_entry_t e;
        e = '{ok: 1'b1, op: OP_SB};
        unique case (f3)
            3'd0:    e.op = OP_SB;
            3'd1:    e.op = OP_SH;
            3'd2:    e.op = OP_SW;
            default: e = '{ok: 1'b0, op: '0};
        endcase
        return e;
    endfunction

    // Immediate ALU ops other than the shifts
    function automatic logic [OP_W-1:0] opimm_op(input logic [2:0] f3);
        logic [OP_W-1:0] o;
        o = OP_ADDI;
        unique case (f3)
            3'd0:    o = OP_ADDI;
            3'd2:    o = OP_SLTI;
            3'd3:    o = OP_SLTIU;
            3'd4:    o = OP_XORI;
            3'd6:    o = OP_ORI;
            3'd7:    o = OP_ANDI;
            default: o = OP_ADDI;
        endcase
        return o;
    endfunction

    // Register ALU ops with funct7 zero
    function automatic logic [OP_W-1:0] reg_op(input logic [2:0] f3);
        logic [OP_W-1:0] o;
        o = OP_ADD;
        unique case (f3)
            3'd0: o = OP_ADD;
            3'd1: o = OP_SLL;
            3'd2: o = OP_SLT;
            3'd3: o = OP_SLTU;
            3'd4: o = OP_XOR;
            3'd5: o = OP_SRL;
            3'd6: o = OP_OR;
            3'd7: o = OP_AND;
        endcase
        return o;
    endfunction

endpackage

// ===== hdl/rvd_decode.sv =====
// Combinational decode of one RV32I instruction word into a dec_result_t.
// Depends on rvd_pkg.
module rvd_decode (
    input  logic [rvd_pkg::INSTR_W-1:0] instr_word,
    output rvd_pkg::dec_result_t        result
);

    logic [6:0]                      opc;
    logic [2:0]                      f3;
    logic [6:0]                      f7;
    logic                            ok;
    logic [rvd_pkg::OP_W-1:0]        op;
    logic [rvd_pkg::FMT_W-1:0]       fmt;
    logic                            s1;
    logic                            s2;
    logic                            d;
    logic [rvd_pkg::IMM_W-1:0]       imm;
    logic [rvd_pkg::IMM_W-1:0]       imm_i;
    logic [rvd_pkg::IMM_W-1:0]       imm_sh;
    rvd_pkg::op_entry_t              ent;

    assign opc    = instr_word[6:0];
    assign f3     = instr_word[14:12];
    assign f7     = instr_word[31:25];
    assign imm_i  = {{20{instr_word[31]}}, instr_word[31:20]};
    assign imm_sh = {27'd0, instr_word[24:20]};

    always_comb
    begin
        ok  = 1'b0;
        op  = '0;
        fmt = rvd_pkg::FMT_U;
        s1  = 1'b0;
        s2  = 1'b0;
        d   = 1'b0;
        imm = '0;
        ent = '0;
        unique case (opc)
            rvd_pkg::OPC_LUI, rvd_pkg::OPC_AUIPC:
            begin
                ok  = 1'b1;
                op  = (opc == rvd_pkg::OPC_LUI) ? rvd_pkg::OP_LUI : rvd_pkg::OP_AUIPC;
                d   = 1'b1;
                imm = {instr_word[31:12], 12'd0};
            end
            rvd_pkg::OPC_JAL:
            begin
                ok  = 1'b1;
                op  = rvd_pkg::OP_JAL;
                fmt = rvd_pkg::FMT_J;
                d   = 1'b1;
                imm = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                       instr_word[30:21], 1'b0};
            end
            rvd_pkg::OPC_JALR:
            begin
                ok  = (f3 == rvd_pkg::F3_ADD);
                op  = rvd_pkg::OP_JALR;
                fmt = rvd_pkg::FMT_I;
                s1  = 1'b1;
                d   = 1'b1;
                imm = imm_i;
            end
            rvd_pkg::OPC_OPIMM:
            begin
                fmt = rvd_pkg::FMT_I;
                s1  = 1'b1;
                d   = 1'b1;
                priority if (f3 == rvd_pkg::F3_SLL)
                begin
                    ok  = (f7 == rvd_pkg::F7_ZERO);
                    op  = rvd_pkg::OP_SLLI;
                    imm = imm_sh;
                end
                else if (f3 == rvd_pkg::F3_SRL)
                begin
                    ok  = (f7 == rvd_pkg::F7_ZERO) || (f7 == rvd_pkg::F7_ALT);
                    op  = (f7 == rvd_pkg::F7_ZERO) ? rvd_pkg::OP_SRLI : rvd_pkg::OP_SRAI;
                    imm = imm_sh;
                end
                else
                begin
                    ok  = 1'b1;
                    op  = rvd_pkg::opimm_op(f3);
                    imm = imm_i;
                end
            end
            rvd_pkg::OPC_LOAD:
            begin
                ent = rvd_pkg::load_op(f3);
                ok  = ent.ok;
                op  = ent.op;
                fmt = rvd_pkg::FMT_L;
                s1  = 1'b1;
                d   = 1'b1;
                imm = imm_i;
            end
            rvd_pkg::OPC_BRANCH:
            begin
                ent = rvd_pkg::branch_op(f3);
                ok  = ent.ok;
                op  = ent.op;
                fmt = rvd_pkg::FMT_B;
                s1  = 1'b1;
                s2  = 1'b1;
                imm = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                       instr_word[11:8], 1'b0};
            end
            rvd_pkg::OPC_OP:
            begin
                fmt = rvd_pkg::FMT_R;
                s1  = 1'b1;
                s2  = 1'b1;
                d   = 1'b1;
                priority if (f7 == rvd_pkg::F7_ZERO)
                begin
                    ok = 1'b1;
                    op = rvd_pkg::reg_op(f3);
                end
                else if (f7 == rvd_pkg::F7_ALT && f3 == rvd_pkg::F3_ADD)
                begin
                    ok = 1'b1;
                    op = rvd_pkg::OP_SUB;
                end
                else if (f7 == rvd_pkg::F7_ALT && f3 == rvd_pkg::F3_SRL)
                begin
                    ok = 1'b1;
                    op = rvd_pkg::OP_SRA;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            rvd_pkg::OPC_STORE:
            begin
                ent = rvd_pkg::store_op(f3);
                ok  = ent.ok;
                op  = ent.op;
                fmt = rvd_pkg::FMT_S;
                s1  = 1'b1;
                s2  = 1'b1;
                imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Zero every field of an illegal word; mask unused register numbers
    always_comb
    begin
        result           = '0;
        result.illegal   = !ok;
        if (ok)
        begin
            result.op        = op;
            result.format    = fmt;
            result.src1_used = s1;
            result.src1_reg  = s1 ? instr_word[19:15] : '0;
            result.src2_used = s2;
            result.src2_reg  = s2 ? instr_word[24:20] : '0;
            result.dest_used = d;
            result.dest_reg  = d ? instr_word[11:7] : '0;
            result.immediate = imm;
        end
    end

endmodule

// ===== hdl/rv32i_instruction_decoder.sv =====
// Top level of the RV32I instruction decoder: input register, decode logic,
// result register and stream handshakes. Depends on rvd_pkg and rvd_decode.
//
// Usage:
//   Slave stream (s_axis_*) takes one 32-bit instruction word per request.
//   Master stream (m_axis_*) returns one decode result per request, in order.
//   m_axis_tuser says what the result is: the format class and the illegal
//   flag. m_axis_tdata carries the operation, register numbers with their
//   used flags and the sign-extended immediate. An illegal word returns
//   illegal = 1 with every other field zero.
// Pipeline and throughput:
//   An accepted request is loaded into the input register; its decode is then
//   loaded into the result register, where m_axis_tvalid rises. One request
//   per cycle sustained while m_axis_tready is high; the only loop is the
//   valid/ready chain of the two pipeline registers.
// Reset:
//   rst_n low clears both valid bits at once; no results are pending after.
// Stall:
//   When m_axis_tready is low the result holds; the input register still
//   takes a new request while it is empty, then s_axis_tready drops until
//   the result is taken. No request is dropped or duplicated.
module rv32i_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] instr_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] op, [10:6] src1_reg, [11] src1_used, [16:12] src2_reg,
    // [17] src2_used, [22:18] dest_reg, [23] dest_used, [55:24] immediate
    output logic [55:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser    // [2:0] format, [3] illegal
);

    logic                             in_valid_reg;
    logic [rvd_pkg::INSTR_W-1:0]      instr_reg;
    logic                             out_valid_reg;
    rvd_pkg::dec_result_t             result_reg;
    rvd_pkg::dec_result_t             result_next;
    logic                             out_advance;
    logic                             in_advance;

    // Result stage moves when empty or being drained; input stage moves when
    // empty or when its word is passing into the result stage.
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign in_advance    = !in_valid_reg || out_advance;
    assign s_axis_tready = in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers: load only on a live request
    always_ff @(posedge clk)
    begin
        if (in_advance && s_axis_tvalid)
        begin
            instr_reg <= s_axis_tdata;
        end
        if (out_advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    rvd_decode u_decode (
        .instr_word (instr_reg),
        .result     (result_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result_reg.immediate,
                            result_reg.dest_used, result_reg.dest_reg,
                            result_reg.src2_used, result_reg.src2_reg,
                            result_reg.src1_used, result_reg.src1_reg,
                            result_reg.op};
    assign m_axis_tuser  = {result_reg.illegal, result_reg.format};

`ifndef SYNTH
    // An illegal result carries no other information
    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.illegal) |->
            (result_reg.op == '0 && result_reg.format == '0 &&
             !result_reg.src1_used && !result_reg.src2_used &&
             !result_reg.dest_used && result_reg.immediate == '0))
        else $error("illegal result has nonzero fields");

    // Anything that reads the second source also reads the first
    a_src_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && result_reg.src2_used) |-> result_reg.src1_used)
        else $error("src2 used without src1");

    // Legal results stay within the operation and format ranges
    a_legal_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !result_reg.illegal) |->
            (result_reg.op <= rvd_pkg::OP_LAST && result_reg.format <= rvd_pkg::FMT_S))
        else $error("legal result out of range");

    // A taken request occupies the input stage in the next cycle
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted request lost");

    // A stage holding a word that cannot move keeps the input side closed
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted over a full pipeline");
`endif

endmodule
